>>> rtl/core/jsonpath_segment_parser_defines.svh
// assertion macros for the path parser checker
`ifndef JSONPATH_SEGMENT_PARSER_DEFINES_SVH
`define JSONPATH_SEGMENT_PARSER_DEFINES_SVH

// same-cycle implication, off while in reset
`define JPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define JPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define JPS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jps_pkg.sv
// shared types and codes of the path parser
package jps_pkg;

  localparam int VAL_W   = 31;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int OUT_TDATA_W = 48;

  // result kinds
  typedef enum logic [2:0] {
    KIND_KEY_BYTE = 3'd0,
    KIND_KEY_END  = 3'd1,
    KIND_INDEX    = 3'd2,
    KIND_OK       = 3'd3,
    KIND_ERR      = 3'd4
  } kind_t;

  // error codes
  localparam logic [2:0] ERR_NO_ROOT     = 3'd0;
  localparam logic [2:0] ERR_EMPTY_DOT   = 3'd1;
  localparam logic [2:0] ERR_BAD_BRACKET = 3'd2;
  localparam logic [2:0] ERR_UNEXPECTED  = 3'd3;
  localparam logic [2:0] ERR_EMPTY_FIRST = 3'd4;

  // one result: kind plus its payload (byte, index or error code)
  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   val;
  } res_t;

  // all results caused by one input byte, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    res_t [MAX_RES-1:0]         r;
  } bundle_t;

endpackage

>>> rtl/core/jps_front.sv
// front end: accepts path bytes, runs the tokenizer and builds result bundles
module jps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  output logic              push_valid,
  output jps_pkg::bundle_t  push_data
);
  import jps_pkg::*;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBR    = 8'h5B;
  localparam logic [7:0] CH_RBR    = 8'h5D;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [VAL_W-1:0] IDX_MAX = {VAL_W{1'b1}};

  typedef enum logic [2:0] {
    PH_START, PH_SEG, PH_DOTNEW, PH_DOTKEY, PH_BOPEN, PH_INDEX, PH_QUOTED, PH_QCLOSE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [VAL_W-1:0] idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             dq_r, dq_nxt;
  logic             esc_r, esc_nxt;
  logic             err_r, err_nxt;
  logic [2:0]       code_r, code_nxt;
  logic             shred_r;

  logic             accept;
  logic [7:0]       c;
  logic             is_num, is_key;
  logic [VAL_W+3:0] mul;
  logic             tb_v;
  res_t             tb;
  logic             use_fin;
  logic [1:0]       fin_n;
  res_t             fin0, fin1;
  logic             f_err;
  logic [2:0]       f_code;
  phase_t           f_phase;
  logic [CNT_W-1:0] cnt;

  assign accept   = in_tvalid & in_tready;
  assign c        = in_tdata;
  assign is_num   = (c >= 8'h30) && (c <= 8'h39);
  assign is_key   = is_num || ((c >= 8'h61) && (c <= 8'h7A)) ||
                    ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_US);
  // idx * 10 + digit
  assign mul = {1'b0, idx_r, 3'b000} + {3'b000, idx_r, 1'b0} + {31'd0, c[3:0]};

  // per-byte tokenizer step
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    ovf_nxt   = ovf_r;
    dq_nxt    = dq_r;
    esc_nxt   = esc_r;
    err_nxt   = err_r;
    code_nxt  = code_r;
    tb_v      = 1'b0;
    tb        = '{kind: KIND_KEY_BYTE, val: '0};
    if (!err_r) begin
      unique case (phase_r)
        PH_START: begin
          if (!shred_r) begin
            if (c == CH_DOLLAR) begin
              phase_nxt = PH_SEG;
            end else begin
              err_nxt = 1'b1; code_nxt = ERR_NO_ROOT;
            end
          end else if (c == CH_LBR) begin
            phase_nxt = PH_BOPEN;
          end else if (is_key) begin
            tb_v = 1'b1; tb.val = {23'd0, c};
            phase_nxt = PH_DOTKEY;
          end else begin
            err_nxt = 1'b1; code_nxt = ERR_EMPTY_FIRST;
          end
        end
        PH_SEG, PH_DOTKEY: begin
          if (phase_r == PH_DOTKEY && is_key) begin
            tb_v = 1'b1; tb.val = {23'd0, c};
          end else begin
            if (phase_r == PH_DOTKEY) begin
              tb_v = 1'b1; tb.kind = KIND_KEY_END;
            end
            // start of the next segment
            if (c == CH_DOT) begin
              phase_nxt = PH_DOTNEW;
            end else if (c == CH_LBR) begin
              phase_nxt = PH_BOPEN;
            end else begin
              err_nxt = 1'b1; code_nxt = ERR_UNEXPECTED;
            end
          end
        end
        PH_DOTNEW: begin
          if (is_key) begin
            tb_v = 1'b1; tb.val = {23'd0, c};
            phase_nxt = PH_DOTKEY;
          end else begin
            err_nxt = 1'b1; code_nxt = ERR_EMPTY_DOT;
          end
        end
        PH_BOPEN: begin
          if (is_num) begin
            idx_nxt = {27'd0, c[3:0]};
            ovf_nxt = 1'b0;
            phase_nxt = PH_INDEX;
          end else if (c == CH_SQ || c == CH_DQ) begin
            dq_nxt = (c == CH_DQ);
            esc_nxt = 1'b0;
            phase_nxt = PH_QUOTED;
          end else begin
            err_nxt = 1'b1; code_nxt = ERR_BAD_BRACKET;
          end
        end
        PH_INDEX: begin
          if (is_num) begin
            if (mul[VAL_W+3:VAL_W] != 4'd0) begin
              idx_nxt = IDX_MAX;
              ovf_nxt = 1'b1;
            end else begin
              idx_nxt = mul[VAL_W-1:0];
            end
          end else if (c == CH_RBR && !ovf_r) begin
            tb_v = 1'b1; tb.kind = KIND_INDEX; tb.val = idx_r;
            idx_nxt = '0;
            phase_nxt = PH_SEG;
          end else begin
            err_nxt = 1'b1; code_nxt = ERR_BAD_BRACKET;
          end
        end
        PH_QUOTED: begin
          if (esc_r) begin
            tb_v = 1'b1;
            if (c == CH_N)      tb.val = 31'd10;
            else if (c == CH_T) tb.val = 31'd9;
            else if (c == CH_R) tb.val = 31'd13;
            else                tb.val = {23'd0, c};
            esc_nxt = 1'b0;
          end else if (c == (dq_r ? CH_DQ : CH_SQ)) begin
            phase_nxt = PH_QCLOSE;
          end else if (c == CH_BSL) begin
            esc_nxt = 1'b1;
          end else begin
            tb_v = 1'b1; tb.val = {23'd0, c};
          end
        end
        PH_QCLOSE: begin
          if (c == CH_RBR) begin
            tb_v = 1'b1; tb.kind = KIND_KEY_END;
            phase_nxt = PH_SEG;
          end else begin
            err_nxt = 1'b1; code_nxt = ERR_BAD_BRACKET;
          end
        end
      endcase
    end
  end

  // end-of-path report, from the cleared state for an empty-path item
  always_comb begin
    f_err   = in_tuser ? 1'b0 : err_nxt;
    f_code  = code_nxt;
    f_phase = in_tuser ? PH_START : phase_nxt;
    fin_n   = 2'd1;
    fin0    = '{kind: KIND_OK, val: '0};
    fin1    = '{kind: KIND_OK, val: '0};
    if (f_err) begin
      fin0 = '{kind: KIND_ERR, val: {28'd0, f_code}};
    end else begin
      unique case (f_phase)
        PH_SEG:    fin0 = '{kind: KIND_OK, val: '0};
        PH_DOTKEY: begin
          fin_n = 2'd2;
          fin0  = '{kind: KIND_KEY_END, val: '0};
        end
        PH_START: begin
          if (!shred_r) fin0 = '{kind: KIND_ERR, val: {28'd0, ERR_NO_ROOT}};
        end
        PH_DOTNEW: fin0 = '{kind: KIND_ERR, val: {28'd0, ERR_EMPTY_DOT}};
        default:   fin0 = '{kind: KIND_ERR, val: {28'd0, ERR_BAD_BRACKET}};
      endcase
    end
  end

  // pack the bundle: step result first, then the end-of-path results
  always_comb begin
    use_fin = in_tuser | in_tlast;
    if (in_tuser) begin
      cnt = fin_n;
      push_data.r[0] = fin0;
      push_data.r[1] = fin1;
    end else begin
      cnt = {1'b0, tb_v} + (use_fin ? fin_n : 2'd0);
      push_data.r[0] = tb_v ? tb : fin0;
      push_data.r[1] = tb_v ? fin0 : fin1;
    end
    push_data.r[2] = fin1;
    push_data.cnt  = cnt;
  end

  assign push_valid = accept && (cnt != '0);

  // parser state and mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
      dq_r    <= 1'b0;
      esc_r   <= 1'b0;
      err_r   <= 1'b0;
      code_r  <= ERR_NO_ROOT;
      shred_r <= 1'b0;
    end else begin
      if (cfg_valid) shred_r <= cfg_data;
      if (accept) begin
        if (use_fin) begin
          phase_r <= PH_START;
          idx_r   <= '0;
          ovf_r   <= 1'b0;
          dq_r    <= 1'b0;
          esc_r   <= 1'b0;
          err_r   <= 1'b0;
          code_r  <= ERR_NO_ROOT;
        end else begin
          phase_r <= phase_nxt;
          idx_r   <= idx_nxt;
          ovf_r   <= ovf_nxt;
          dq_r    <= dq_nxt;
          esc_r   <= esc_nxt;
          err_r   <= err_nxt;
          code_r  <= code_nxt;
        end
      end
    end
  end

endmodule

>>> rtl/core/jps_queue.sv
// short bundle queue between the front and back ends
module jps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jps_pkg::bundle_t  push_data,
  input  logic              pop,
  output jps_pkg::bundle_t  head,
  output logic              empty,
  output logic              full
);
  import jps_pkg::*;

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QDEPTH[QPTR_W:0]);
  assign head  = mem[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/core/jps_back.sv
// back end: unpacks bundles into one result beat per cycle while out_tready allows
module jps_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  jps_pkg::bundle_t                 head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [jps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic [2:0]                       out_tuser
);
  import jps_pkg::*;

  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r, data_nxt;
  logic                   last_r;
  logic [2:0]             kind_r;
  logic [CNT_W-1:0]       sel_r;
  logic                   load, last_res;
  res_t                   cur;

  assign load     = !empty && (!valid_r || out_tready);
  assign cur      = head.r[sel_r];
  assign last_res = (sel_r == head.cnt - 1'b1);
  assign pop      = load && last_res;

  // fields that do not belong to the kind stay zero
  always_comb begin
    data_nxt = '0;
    case (cur.kind)
      KIND_KEY_BYTE: data_nxt[7:0]   = cur.val[7:0];
      KIND_INDEX:    data_nxt[38:8]  = cur.val;
      KIND_ERR:      data_nxt[41:39] = cur.val[2:0];
      default:       data_nxt = '0;
    endcase
  end

  // output register and slot select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      sel_r   <= last_res ? '0 : sel_r + 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= last_res;
      kind_r <= cur.kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = kind_r;

endmodule

>>> rtl/core/jsonpath_segment_parser.sv
// top level of the streaming path tokenizer
// One path byte is taken per cycle whenever the four-entry bundle queue has
// room. Each byte yields zero to three result beats, which the output register
// gives out at one beat per cycle while out_tready is high, so bytes flow at
// one per cycle as long as they average no more than one result each; the
// output port's drain rate is what sets the sustained figure. A byte's results
// pass through the queue entry written when the byte is taken, then the output
// register. The mode register is to be written through the cfg port only while
// the block is idle; the user must keep to this, the block does not enforce it.
module jsonpath_segment_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,    // shredded_mode
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,    // path_byte
  input  logic                             in_tlast,    // final_byte
  input  logic                             in_tuser,    // empty_path
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // key_byte [7:0], index_value [38:8], error_code [41:39], zero pad
  output logic [jps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,   // run_end
  output logic [2:0]                       out_tuser    // token_kind
);
  import jps_pkg::*;

  logic    push_valid, pop, q_empty, q_full;
  bundle_t push_data, head;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  jps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  jps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  jps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/jps_checker.sv
// port-level checks of the path parser and their bind
`include "jsonpath_segment_parser_defines.svh"

module jps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [jps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tlast,
  input logic [2:0]                       out_tuser
);
  import jps_pkg::*;

  // a stalled result beat holds
  `JPS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result beat changed while stalled")

  // a path report always closes the run of its byte
  `JPS_ASSERT_IMP(a_report_last, out_tvalid && (out_tuser == KIND_OK || out_tuser == KIND_ERR), out_tlast, "path report without run end")

  // only key byte beats carry a byte
  `JPS_ASSERT_IMP(a_byte_zero, out_tvalid && out_tuser != KIND_KEY_BYTE, out_tdata[7:0] == 8'd0, "key byte set on a non-byte beat")

  // reset empties the output
  `JPS_ASSERT_RST(a_rst_idle, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind jsonpath_segment_parser jps_checker u_jps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> bench/jsonpath_segment_parser_tb.sv
// self-checking testbench for the streaming path tokenizer: random and directed paths
module jsonpath_segment_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jps_pkg::*;

  // path characters the tokenizer reacts to
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_LBRK   = "[";
  localparam logic [7:0] CH_RBRK   = "]";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_LC_N   = "n";
  localparam logic [7:0] CH_LC_T   = "t";
  localparam logic [7:0] CH_LC_R   = "r";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;

  localparam logic [30:0] INDEX_CEIL = 31'h7fff_ffff;
  localparam int RANDOM_BEATS = 300;
  localparam int DRAIN_LIMIT  = 5000;

  // where the tokenizer stands inside a path
  typedef enum logic [3:0] {
    AT_ROOT, AFTER_SEG, AFTER_DOT, IN_KEY, IN_BRACKET, IN_INDEX, IN_QUOTE, AFTER_QUOTE
  } phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       emp;
  } path_beat_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  kbyte;
    logic [30:0] idx;
    logic [2:0]  code;
    logic        last;
  } token_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;     // path_byte
  logic                   in_tlast = 1'b0;   // final_byte
  logic                   in_tuser = 1'b0;   // empty_path
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // key_byte, index_value, error_code, pad
  logic                   out_tlast;         // run_end
  logic [2:0]             out_tuser;         // token_kind

  jsonpath_segment_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // pending path beats and tokens still owed by the block
  path_beat_t beat_q[$];
  token_t     token_q[$];
  logic [7:0] txt[$];

  // tokenizer mirror
  logic        shred = 1'b0;
  phase_e      ph = AT_ROOT;
  logic [30:0] idx_acc = '0;
  logic        idx_sat = 1'b0;
  logic        dq = 1'b0;
  logic        esc = 1'b0;
  logic        bad = 1'b0;
  logic [2:0]  bad_code = '0;
  token_t      res_buf[MAX_RES];
  int          res_n;

  // handshake bookkeeping
  logic       in_took = 1'b0;
  logic       out_took = 1'b0;
  logic       quiet = 1'b0;
  logic       send_busy = 1'b0;
  path_beat_t send_cur = '0;
  int         send_wait = 0;
  int         take_wait = 0;
  logic       take_rdy;

  int miss_count = 0;
  int beats_queued = 0;
  int beats_in = 0;
  int results_seen = 0;
  int paths_ok = 0;
  int paths_bad = 0;
  int index_tokens = 0;

  task automatic report_miss(string msg);
    miss_count++;
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  function automatic int idle_draw();
    if (quiet) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_key(logic [7:0] c);
    return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == CH_UNDER;
  endfunction

  // ---------------------------------------------------------------- prediction

  task automatic emit(kind_t kd, logic [7:0] kb, logic [30:0] ix, logic [2:0] cd);
    if (res_n < MAX_RES) begin
      res_buf[res_n].kind  = kd;
      res_buf[res_n].kbyte = kb;
      res_buf[res_n].idx   = ix;
      res_buf[res_n].code  = cd;
      res_buf[res_n].last  = 1'b0;
      res_n++;
    end
  endtask

  task automatic latch_error(logic [2:0] cd);
    bad = 1'b1;
    bad_code = cd;
  endtask

  task automatic clear_path();
    ph = AT_ROOT;
    idx_acc = '0;
    idx_sat = 1'b0;
    dq = 1'b0;
    esc = 1'b0;
    bad = 1'b0;
    bad_code = '0;
  endtask

  task automatic open_segment(logic [7:0] c);
    if (c == CH_DOT) ph = AFTER_DOT;
    else if (c == CH_LBRK) ph = IN_BRACKET;
    else latch_error(ERR_UNEXPECTED);
  endtask

  task automatic scan_byte(logic [7:0] c);
    longint unsigned grown;
    logic [7:0] dec;
    case (ph)
      AT_ROOT: begin
        if (!shred) begin
          if (c == CH_DOLLAR) ph = AFTER_SEG;
          else latch_error(ERR_NO_ROOT);
        end else if (c == CH_LBRK) begin
          ph = IN_BRACKET;
        end else if (is_key(c)) begin
          emit(KIND_KEY_BYTE, c, '0, '0);
          ph = IN_KEY;
        end else begin
          latch_error(ERR_EMPTY_FIRST);
        end
      end
      AFTER_SEG: open_segment(c);
      AFTER_DOT: begin
        if (is_key(c)) begin
          emit(KIND_KEY_BYTE, c, '0, '0);
          ph = IN_KEY;
        end else begin
          latch_error(ERR_EMPTY_DOT);
        end
      end
      IN_KEY: begin
        if (is_key(c)) begin
          emit(KIND_KEY_BYTE, c, '0, '0);
        end else begin
          emit(KIND_KEY_END, '0, '0, '0);
          open_segment(c);
        end
      end
      IN_BRACKET: begin
        if (digit_char(c)) begin
          idx_acc = 31'(c - CH_ZERO);
          idx_sat = 1'b0;
          ph = IN_INDEX;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          dq = (c == CH_DQUOTE);
          esc = 1'b0;
          ph = IN_QUOTE;
        end else begin
          latch_error(ERR_BAD_BRACKET);
        end
      end
      IN_INDEX: begin
        if (digit_char(c)) begin
          // saturate at the largest index and remember it
          grown = longint'(idx_acc) * 10 + longint'(c - CH_ZERO);
          if (grown > longint'(INDEX_CEIL)) begin
            idx_acc = INDEX_CEIL;
            idx_sat = 1'b1;
          end else begin
            idx_acc = 31'(grown);
          end
        end else if (c == CH_RBRK && !idx_sat) begin
          emit(KIND_INDEX, '0, idx_acc, '0);
          idx_acc = '0;
          ph = AFTER_SEG;
        end else begin
          latch_error(ERR_BAD_BRACKET);
        end
      end
      IN_QUOTE: begin
        if (esc) begin
          dec = c;
          if (c == CH_LC_N) dec = CH_NL;
          else if (c == CH_LC_T) dec = CH_TAB;
          else if (c == CH_LC_R) dec = CH_CR;
          emit(KIND_KEY_BYTE, dec, '0, '0);
          esc = 1'b0;
        end else if (c == (dq ? CH_DQUOTE : CH_SQUOTE)) begin
          ph = AFTER_QUOTE;
        end else if (c == CH_BSLASH) begin
          esc = 1'b1;
        end else begin
          emit(KIND_KEY_BYTE, c, '0, '0);
        end
      end
      AFTER_QUOTE: begin
        if (c == CH_RBRK) begin
          emit(KIND_KEY_END, '0, '0, '0);
          ph = AFTER_SEG;
        end else begin
          latch_error(ERR_BAD_BRACKET);
        end
      end
      default: latch_error(ERR_BAD_BRACKET);
    endcase
  endtask

  // end-of-path verdict
  task automatic close_path();
    if (bad) begin
      emit(KIND_ERR, '0, '0, bad_code);
    end else begin
      case (ph)
        AFTER_SEG: emit(KIND_OK, '0, '0, '0);
        IN_KEY: begin
          emit(KIND_KEY_END, '0, '0, '0);
          emit(KIND_OK, '0, '0, '0);
        end
        AT_ROOT: begin
          if (shred) emit(KIND_OK, '0, '0, '0);
          else emit(KIND_ERR, '0, '0, ERR_NO_ROOT);
        end
        AFTER_DOT: emit(KIND_ERR, '0, '0, ERR_EMPTY_DOT);
        default: emit(KIND_ERR, '0, '0, ERR_BAD_BRACKET);
      endcase
    end
  endtask

  task automatic predict_beat(path_beat_t bt);
    int k;
    res_n = 0;
    if (bt.emp) begin
      clear_path();
      close_path();
      clear_path();
    end else begin
      if (!bad) scan_byte(bt.b);
      if (bt.fin) begin
        close_path();
        clear_path();
      end
    end
    for (k = 0; k < res_n; k++) begin
      res_buf[k].last = (k == res_n - 1);
      token_q.insert(token_q.size(), res_buf[k]);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_result();
    token_t want;
    if (token_q.size() == 0) begin
      report_miss($sformatf("result kind %0d data %h with nothing expected",
                            out_tuser, out_tdata));
    end else begin
      want = token_q.pop_front();
      results_seen++;
      if (out_tuser !== want.kind)
        report_miss($sformatf("kind %0d, expected %0d", out_tuser, want.kind));
      if (out_tdata[7:0] !== want.kbyte)
        report_miss($sformatf("key byte %h, expected %h", out_tdata[7:0], want.kbyte));
      if (out_tdata[38:8] !== want.idx)
        report_miss($sformatf("index %0d, expected %0d", out_tdata[38:8], want.idx));
      if (out_tdata[41:39] !== want.code)
        report_miss($sformatf("error code %0d, expected %0d", out_tdata[41:39], want.code));
      if (out_tdata[47:42] !== '0)
        report_miss($sformatf("pad bits %b not zero", out_tdata[47:42]));
      if (out_tlast !== want.last)
        report_miss($sformatf("run end %b, expected %b", out_tlast, want.last));
      if (want.kind == KIND_OK) paths_ok++;
      if (want.kind == KIND_ERR) paths_bad++;
      if (want.kind == KIND_INDEX) index_tokens++;
    end
  endtask

  // monitor: predict on each accepted byte, check each result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        beats_in++;
        predict_beat('{b: in_tdata, fin: in_tlast, emp: in_tuser});
      end
      if (out_tvalid && out_tready) check_result();
    end
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
  end

  // byte driver with a random gap before each beat
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_took) begin
        send_busy = 1'b0;
        send_wait = idle_draw();
      end
      if (!send_busy && send_wait == 0 && beat_q.size() > 0) begin
        send_cur = beat_q.pop_front();
        send_busy = 1'b1;
      end else if (!send_busy && send_wait > 0) begin
        send_wait--;
      end
    end
    in_tvalid <= send_busy;
    in_tdata  <= send_cur.b;
    in_tlast  <= send_cur.fin;
    in_tuser  <= send_cur.emp;
  end

  // result sink with a random stall after each beat
  always @(negedge clk) begin
    take_rdy = 1'b1;
    if (out_took) take_wait = idle_draw();
    if (take_wait > 0) begin
      take_wait--;
      take_rdy = 1'b0;
    end
    out_tready <= take_rdy;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_beat(logic [7:0] b, logic fin, logic emp);
    path_beat_t bt;
    bt = '{b: b, fin: fin, emp: emp};
    beat_q.insert(beat_q.size(), bt);
    beats_queued++;
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1, 1'b0);
  endtask

  task automatic send_txt();
    int i;
    for (i = 0; i < txt.size(); i++) push_beat(txt[i], i == txt.size() - 1, 1'b0);
  endtask

  task automatic push_empty();
    push_beat(8'($urandom()), 1'($urandom()), 1'b1);
  endtask

  function automatic logic [7:0] key_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return 8'("a") + 8'(r - 10);
    if (r < 62) return 8'("A") + 8'(r - 36);
    return CH_UNDER;
  endfunction

  task automatic add_index();
    string s;
    int i;
    case ($urandom_range(0, 6))
      0: s = $sformatf("%0d", $urandom_range(0, 9));
      1: s = $sformatf("%0d", $urandom_range(0, 99999));
      2: s = "2147483647";
      3: s = "2147483648";
      4: s = $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom_range(10000, 99999));
      5: s = "99999999999999";
      default: s = $sformatf("00%0d", $urandom_range(0, 999));
    endcase
    txt.insert(txt.size(), CH_LBRK);
    for (i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
    txt.insert(txt.size(), CH_RBRK);
  endtask

  // quoted key with random content and escapes
  task automatic add_quoted();
    logic [7:0] q;
    logic [7:0] c;
    int n;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    txt.insert(txt.size(), CH_LBRK);
    txt.insert(txt.size(), q);
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        txt.insert(txt.size(), CH_BSLASH);
        case ($urandom_range(0, 3))
          0: txt.insert(txt.size(), CH_LC_N);
          1: txt.insert(txt.size(), CH_LC_T);
          2: txt.insert(txt.size(), CH_LC_R);
          default: txt.insert(txt.size(), 8'($urandom()));
        endcase
      end else begin
        c = 8'($urandom());
        while (c == q || c == CH_BSLASH) c = 8'($urandom());
        txt.insert(txt.size(), c);
      end
    end
    txt.insert(txt.size(), q);
    txt.insert(txt.size(), CH_RBRK);
  endtask

  // well-formed path for the given mode
  task automatic gen_path(logic mode);
    int segs;
    int i;
    txt.delete();
    segs = $urandom_range(0, 4);
    if (!mode) txt.insert(txt.size(), CH_DOLLAR);
    for (i = 0; i < segs; i++) begin
      case ($urandom_range(0, 2))
        0: begin
          if (!(mode && i == 0)) txt.insert(txt.size(), CH_DOT);
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), key_char());
        end
        1: add_index();
        default: add_quoted();
      endcase
    end
  endtask

  // damage a path: overwrite, truncate, trailing dot or stray byte
  task automatic corrupt();
    int keep;
    case ($urandom_range(0, 3))
      0: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom());
      1: begin
        keep = $urandom_range(1, txt.size());
        while (txt.size() > keep) txt.delete(txt.size() - 1);
      end
      2: txt.insert(txt.size(), CH_DOT);
      default: txt.insert($urandom_range(0, txt.size()), 8'($urandom()));
    endcase
  endtask

  task automatic random_phase(logic mode, int want);
    int start;
    int pick;
    int i;
    start = beats_queued;
    while (beats_queued - start < want) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push_empty();
      end else if (pick == 1) begin
        // pure noise
        txt.delete();
        repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom()));
        send_txt();
      end else begin
        gen_path(mode);
        if (pick == 2 && txt.size() > 1) begin
          // path cut short by an empty-path beat
          for (i = 0; i < txt.size() - 1; i++) push_beat(txt[i], 1'b0, 1'b0);
          push_empty();
        end else begin
          if (pick < 7 && txt.size() > 0) corrupt();
          if (txt.size() == 0) push_empty();
          else send_txt();
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || in_tvalid || token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shred = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p;
    int rnd_start;
    int waited;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full mode after reset: root checks, dotted, bracket, escape, overflow, errors
    push_beat(8'hA5, 1'b0, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_text("$[0]");
    push_text("$.z.");
    push_text("$['\\t']");
    push_text("$[2147483648]");
    push_text("$x");
    push_text("$[");
    wait_idle();

    // shredded mode: empty path, empty first key, bare key
    write_mode(1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    push_text(".");
    push_text("a");
    push_beat(8'h00, 1'b1, 1'b0);

    // random phases alternating the mode, the third one without idling
    rnd_start = beats_queued;
    p = 0;
    while (beats_queued - rnd_start < RANDOM_BEATS) begin
      wait_idle();
      write_mode(p[0]);
      quiet = (p == 2);
      random_phase(p[0], 60);
      p++;
    end

    // drain, bounded
    while (beat_q.size() != 0 || in_tvalid) @(posedge clk);
    waited = 0;
    while (token_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (token_q.size() != 0)
      report_miss($sformatf("%0d expected results never arrived", token_q.size()));

    $display("covered %0d path beats in %0d mode settings: %0d results, %0d indices,",
             beats_in, p + 2, results_seen, index_tokens);
    $display("%0d paths accepted and %0d rejected", paths_ok, paths_bad);
    if (miss_count == 0) begin
      $display("jsonpath_segment_parser verification clean");
    end else begin
      $display("jsonpath_segment_parser verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("jsonpath_segment_parser verification failed");
    $finish;
  end

endmodule
